// ===== rtl/core/nmea_ts_pkg.sv =====
`default_nettype none

package nmea_ts_pkg;

  // Width of the per-line character counters
  localparam int unsigned FILL_W = 7;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;

  // Length that a line's text must exceed to carry a sentence
  localparam logic [FILL_W-1:0] MIN_TEXT_LEN = 7'd10;

  // Command codes
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  // Comma and digit tracking codes
  localparam logic [2:0] CDC_NONE  = 3'd0;
  localparam logic [2:0] CDC_FIRST = 3'd1;
  localparam logic [2:0] CDC_LAST  = 3'd6;
  localparam logic [2:0] CDC_DONE  = 3'd7;

  typedef enum logic [1:0] {
    HDR_OPEN   = 2'd0,
    HDR_GGA    = 2'd1,
    HDR_RMC    = 2'd2,
    HDR_REJECT = 2'd3
  } hdr_e;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       time_valid;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } out_item_t;

  // Running state of the line being received
  typedef struct packed {
    logic [FILL_W-1:0] fill_count;
    logic              locked;
    logic [FILL_W-1:0] text_length;
    logic              nul_seen;
    hdr_e              header_match;
    logic [2:0]        comma_digit_count;
    logic [5:0][3:0]   time_digits;
    logic [7:0]        running_xor;
    logic [2:0][7:0]   recent_chars;
  } line_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok    = 1'b1;
      h.value = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  // Combine two decimal digits into a value, tens times ten by shifts
  function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
    return {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmea_ts_state_mem.sv =====
`default_nettype none

module nmea_ts_state_mem
  import nmea_ts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire line_state_t wr_data_i,
  output line_state_t      rd_data_o
);

  line_state_t mem_q [1];
  line_state_t rd_q;
  line_state_t fwd_q;
  logic        fwd_vld_q;
  logic        written_q;

  // Write back the updated state and read it every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[0] <= wr_data_i;
    end
    rd_q <= mem_q[0];
  end

  // Hold the last write for the cycle where the read data is still stale
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fwd_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
      written_q <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en_i;
      if (wr_en_i) begin
        written_q <= 1'b1;
      end
    end
  end

  // Forward the fresh write, else the stored entry, else the reset state
  always_comb begin
    if (fwd_vld_q) begin
      rd_data_o = fwd_q;
    end else if (written_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nmea_ts_update.sv =====
`default_nettype none

module nmea_ts_update
  import nmea_ts_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 82
) (
  input  wire line_state_t cur_i,
  input  wire in_item_t    item_i,
  output line_state_t      nxt_o,
  output logic             res_vld_o,
  output out_item_t        res_o
);

  localparam logic [FILL_W-1:0] LineLim = FILL_W'(LINE_BYTES);

  logic [7:0]        c;
  logic [FILL_W-1:0] fc;
  hex_t              hx1;
  hex_t              hx0;
  logic [7:0]        sum;
  logic [7:0]        chk;
  logic              ok;
  line_state_t       nxt;
  logic [2:0]        didx;

  assign c = item_i.data_byte;

  // Wrap on overflow, restart on '$'
  always_comb begin
    fc = (cur_i.fill_count >= LineLim) ? '0 : cur_i.fill_count;
    if (c == CH_DOLLAR) begin
      fc = '0;
    end
  end

  // Evaluate the checksum and the line checks for a carriage return
  always_comb begin
    hx1 = hex_digit(cur_i.recent_chars[1]);
    hx0 = hex_digit(cur_i.recent_chars[0]);
    sum = '0;
    if (hx1.ok) begin
      sum = hx0.ok ? {hx1.value, hx0.value} : {4'h0, hx1.value};
    end
    chk = cur_i.running_xor ^ cur_i.recent_chars[0] ^ cur_i.recent_chars[1]
          ^ cur_i.recent_chars[2];
    ok = (fc != '0)
         && (cur_i.header_match == HDR_GGA || cur_i.header_match == HDR_RMC)
         && (cur_i.text_length > MIN_TEXT_LEN)
         && (cur_i.comma_digit_count == CDC_DONE)
         && (sum != 8'h00)
         && (chk == sum);
  end

  // Advance the line state by one transaction
  always_comb begin
    nxt       = cur_i;
    res_vld_o = 1'b0;
    didx      = cur_i.comma_digit_count - 3'd1;
    if (item_i.command == CMD_RESYNC) begin
      nxt.locked = 1'b0;
    end else if (!cur_i.locked) begin
      if (c == CH_CR) begin
        res_vld_o      = 1'b1;
        nxt.fill_count = '0;
        if (ok) begin
          nxt.locked = 1'b1;
        end
      end else begin
        if (fc == '0) begin
          nxt.text_length       = '0;
          nxt.nul_seen          = 1'b0;
          nxt.header_match      = HDR_OPEN;
          nxt.comma_digit_count = CDC_NONE;
          nxt.time_digits       = '0;
          nxt.running_xor       = '0;
          nxt.recent_chars      = '0;
        end
        didx = nxt.comma_digit_count - 3'd1;
        if (!nxt.nul_seen) begin
          if (c == CH_NUL) begin
            nxt.nul_seen = 1'b1;
            if (fc == '0) begin
              nxt.header_match = HDR_REJECT;
            end
          end else begin
            // Header check and checksum accumulation
            if (fc == '0) begin
              if (c != CH_DOLLAR) begin
                nxt.header_match = HDR_REJECT;
              end
            end else begin
              if (nxt.header_match != HDR_REJECT) begin
                case (fc)
                  7'd1: if (c != CH_G) nxt.header_match = HDR_REJECT;
                  7'd2: if (c != CH_P) nxt.header_match = HDR_REJECT;
                  7'd3: begin
                    if (c == CH_G) begin
                      nxt.header_match = HDR_GGA;
                    end else if (c == CH_R) begin
                      nxt.header_match = HDR_RMC;
                    end else begin
                      nxt.header_match = HDR_REJECT;
                    end
                  end
                  7'd4: begin
                    if (!((nxt.header_match == HDR_GGA && c == CH_G) ||
                          (nxt.header_match == HDR_RMC && c == CH_M))) begin
                      nxt.header_match = HDR_REJECT;
                    end
                  end
                  7'd5: begin
                    if (!((nxt.header_match == HDR_GGA && c == CH_A) ||
                          (nxt.header_match == HDR_RMC && c == CH_C))) begin
                      nxt.header_match = HDR_REJECT;
                    end
                  end
                  default: ;
                endcase
              end
              nxt.running_xor = nxt.running_xor ^ c;
            end
            // Time digits after the first comma
            if (nxt.comma_digit_count >= CDC_FIRST && nxt.comma_digit_count <= CDC_LAST) begin
              if (c >= 8'h30 && c <= 8'h39) begin
                for (int i = 0; i < 6; i++) begin
                  if (didx == 3'(i)) begin
                    nxt.time_digits[i] = c[3:0];
                  end
                end
                nxt.comma_digit_count = nxt.comma_digit_count + 3'd1;
              end else begin
                nxt.header_match = HDR_REJECT;
              end
            end else if (nxt.comma_digit_count == CDC_NONE && c == CH_COMMA) begin
              nxt.comma_digit_count = CDC_FIRST;
            end
            nxt.recent_chars = {nxt.recent_chars[1], nxt.recent_chars[0], c};
            nxt.text_length  = nxt.text_length + 7'd1;
          end
        end
        nxt.fill_count = fc + 7'd1;
      end
    end
  end

  assign nxt_o = nxt;

  // Build the result, zero time for a rejected line
  always_comb begin
    res_o            = '0;
    res_o.time_valid = ok;
    if (ok) begin
      res_o.hour   = two_digits(cur_i.time_digits[0], cur_i.time_digits[1]);
      res_o.minute = two_digits(cur_i.time_digits[2], cur_i.time_digits[3]);
      res_o.second = two_digits(cur_i.time_digits[4], cur_i.time_digits[5]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nmea_time_sentence_parser.sv =====
`default_nettype none

// NMEA time sentence parser. Feed received UART bytes (command 0) or a resync
// request (command 1) one transaction per cycle unless stalled; a carriage
// return yields one result with the hour, minute and second of a valid $GPGGA
// or $GPRMC line, or time_valid 0 and zero fields. The block sustains one
// transaction per clock unless the output stalls: the line state lives in a
// one-entry synchronous memory that is read, updated and written back every
// cycle, with the last write forwarded over the read register. A result passes
// the input item register, then the output register, where it waits while
// stalled. After a valid result, bytes are dropped until a resync arrives.
module nmea_time_sentence_parser
  import nmea_ts_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 82
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  logic        s2_vld_q;
  logic        s2_vld_d;
  in_item_t    s2_item_q;
  logic        s2_go;
  logic        in_acc;
  logic        out_ready;
  logic        out_vld_q;
  logic        out_vld_d;
  out_item_t   out_q;
  line_state_t cur_state;
  line_state_t nxt_state;
  logic        res_vld;
  out_item_t   res;

  nmea_ts_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s2_go),
    .wr_data_i (nxt_state),
    .rd_data_o (cur_state)
  );

  nmea_ts_update #(
    .LINE_BYTES (LINE_BYTES)
  ) u_update (
    .cur_i     (cur_state),
    .item_i    (s2_item_q),
    .nxt_o     (nxt_state),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Advance the working stage unless its result has nowhere to go
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign s2_go      = s2_vld_q && (!res_vld || out_ready);
  assign in_stall_o = s2_vld_q && !s2_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s2_vld_d = s2_vld_q;
    if (in_acc) begin
      s2_vld_d = 1'b1;
    end else if (s2_go) begin
      s2_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready) begin
      out_vld_d = s2_go && res_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s2_item_q <= in_item_i;
    end
    if (out_ready && s2_go && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/nmea_ts_checker.sv =====
`default_nettype none

module nmea_ts_checker
  import nmea_ts_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o && (in_item_i.command == CMD_BYTE);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // A rejected line carries a zero time
  a_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.time_valid |->
      out_item_o.hour == 7'd0 && out_item_o.minute == 7'd0 && out_item_o.second == 7'd0)
    else $error("rejected line with nonzero time");

  // Time fields are two decimal digits
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_item_o.hour <= 7'd99 && out_item_o.minute <= 7'd99 && out_item_o.second <= 7'd99)
    else $error("time field out of range");

  // A fresh result must trace back to an accepted byte transaction
  a_res_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 2))
    else $error("result without a byte transaction");

endmodule

bind nmea_time_sentence_parser nmea_ts_checker u_nmea_ts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
